### rtl/ehp_pkg.sv
// Package for the Ethernet header parser: ethertype and protocol codes,
// parse phases, result kinds and the structs shared by the parser modules.
// Depends on nothing.
package ehp_pkg;

   // Default sizing of the parser.
   localparam int DEF_MAX_TAGS        = 4;
   localparam int DEF_MAX_FRAME_BYTES = 2048;

   // Position of the last byte of the two MAC addresses.
   localparam int MAC_LAST_POS = 11;

   // Ethertypes and PPP protocol numbers.
   localparam logic [15:0] ETH_VLAN       = 16'h8100;
   localparam logic [15:0] ETH_IPV4       = 16'h0800;
   localparam logic [15:0] ETH_ARP        = 16'h0806;
   localparam logic [15:0] ETH_IPV6       = 16'h86DD;
   localparam logic [15:0] ETH_PPPOE_DISC = 16'h8863;
   localparam logic [15:0] ETH_PPPOE_SESS = 16'h8864;
   localparam logic [15:0] PPP_IPV4       = 16'h0021;
   localparam logic [15:0] PPP_IPV6       = 16'h0057;

   // IPv4 protocol number for UDP and the smallest legal IHL.
   localparam logic [7:0] IP_PROTO_UDP = 8'd17;
   localparam logic [3:0] IHL_MIN      = 4'd5;

   // Layer 3 kind codes.
   localparam logic [2:0] L3_OTHER      = 3'd0;
   localparam logic [2:0] L3_IPV4       = 3'd1;
   localparam logic [2:0] L3_IPV6       = 3'd2;
   localparam logic [2:0] L3_ARP        = 3'd3;
   localparam logic [2:0] L3_PPPOE_DISC = 3'd4;

   // Bit positions in the status flags.
   localparam int FLG_VLAN      = 0;
   localparam int FLG_PPPOE     = 1;
   localparam int FLG_UDP       = 2;
   localparam int FLG_TRUNC     = 3;
   localparam int FLG_TAG_LIMIT = 4;

   // Parse phases.
   typedef enum logic [2:0] {
      PH_MAC,
      PH_ETYPE,
      PH_VLAN,
      PH_PPPOE,
      PH_IPV4,
      PH_DONE
   } phase_type;

   // One frame byte as held in the input register.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } beat_type;

   // One frame summary.
   typedef struct packed {
      logic [2:0]  l3_kind;
      logic [15:0] final_ethertype;
      logic [15:0] vlan_tci;
      logic [4:0]  status_flags;
      logic [15:0] pppoe_session_id;
      logic [15:0] pppoe_length;
      logic [31:0] src_ipv4;
      logic [31:0] dst_ipv4;
      logic [7:0]  ip_protocol;
      logic [15:0] udp_src_port;
      logic [15:0] udp_dst_port;
      logic [15:0] udp_length;
   } rsp_type;

   // Fields gathered while a frame is parsed.
   typedef struct packed {
      logic [2:0]  l3_kind;
      logic [15:0] final_ethertype;
      logic [15:0] vlan_tci;
      logic [4:0]  status_flags;
      logic [15:0] pppoe_session_id;
      logic [15:0] pppoe_length;
      logic [31:0] src_ipv4;
      logic [31:0] dst_ipv4;
      logic [7:0]  ip_protocol;
      logic [15:0] udp_src_port;
      logic [15:0] udp_dst_port;
      logic [15:0] udp_length;
      logic [3:0]  ihl;
   } capture_type;

endpackage

### rtl/ehp_if.sv
// Valid/ready channel interfaces of the Ethernet header parser:
// the byte request channel and the frame summary channel. No dependencies.
interface ehp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ehp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  l3_kind;
   logic [15:0] final_ethertype;
   logic [15:0] vlan_tci;
   logic [4:0]  status_flags;
   logic [15:0] pppoe_session_id;
   logic [15:0] pppoe_length;
   logic [31:0] src_ipv4;
   logic [31:0] dst_ipv4;
   logic [7:0]  ip_protocol;
   logic [15:0] udp_src_port;
   logic [15:0] udp_dst_port;
   logic [15:0] udp_length;

   modport source (
      output valid, input ready,
      output l3_kind, output final_ethertype, output vlan_tci, output status_flags,
      output pppoe_session_id, output pppoe_length, output src_ipv4, output dst_ipv4,
      output ip_protocol, output udp_src_port, output udp_dst_port, output udp_length
   );
   modport sink (
      input valid, output ready,
      input l3_kind, input final_ethertype, input vlan_tci, input status_flags,
      input pppoe_session_id, input pppoe_length, input src_ipv4, input dst_ipv4,
      input ip_protocol, input udp_src_port, input udp_dst_port, input udp_length
   );
endinterface

### rtl/ehp_frame_parser.sv
// Per-frame parse state and the byte decode of the Ethernet header parser.
// Depends on ehp_pkg.
module ehp_frame_parser #(
   parameter int MAX_TAGS        = ehp_pkg::DEF_MAX_TAGS,
   parameter int MAX_FRAME_BYTES = ehp_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              beat_valid,
   input  ehp_pkg::beat_type beat,
   output ehp_pkg::rsp_type  result
);
   import ehp_pkg::*;

   localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
   localparam int TW = $clog2(MAX_TAGS + 1);
   localparam int OW = 7;

   phase_type     phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [OW-1:0] off_ff, off_in;
   logic [TW-1:0] tag_ff, tag_in;
   logic [7:0]    hold_ff, hold_in;
   capture_type   cap_ff, cap_in;

   logic [7:0]    b;
   logic [15:0]   word;
   logic          parse_en;
   logic          do_disp;
   logic [15:0]   disp_type;
   logic [5:0]    hdr_len;
   logic [OW-1:0] udp_off;
   logic [4:0]    flags_out;

   assign b        = beat.data_byte;
   assign word     = {hold_ff, b};
   assign parse_en = (pos_ff < PW'(MAX_FRAME_BYTES));

   // Byte decode, header dispatch and frame summary.
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      off_in    = off_ff;
      tag_in    = tag_ff;
      hold_in   = hold_ff;
      cap_in    = cap_ff;
      do_disp   = 1'b0;
      disp_type = word;
      hdr_len   = {cap_ff.ihl, 2'b00};
      udp_off   = '0;
      flags_out = '0;
      result    = '0;

      if (parse_en) begin
         pos_in = pos_ff + PW'(1);
         if (off_ff != '1) begin
            off_in = off_ff + OW'(1);
         end
         unique case (phase_ff)
            PH_MAC: begin
               if (pos_ff >= PW'(MAC_LAST_POS)) begin
                  phase_in = PH_ETYPE;
                  off_in   = '0;
               end
            end
            PH_ETYPE: begin
               if (off_ff == '0) hold_in = b;
               else              do_disp = 1'b1;
            end
            PH_VLAN: begin
               case (off_ff) inside
                  OW'(0), OW'(2): hold_in = b;
                  OW'(1):         cap_in.vlan_tci = word;
                  default:        do_disp = 1'b1;
               endcase
            end
            PH_PPPOE: begin
               if (!off_ff[0]) begin
                  hold_in = b;
               end else if (off_ff == OW'(3)) begin
                  cap_in.pppoe_session_id = word;
               end else if (off_ff == OW'(5)) begin
                  cap_in.pppoe_length = word;
               end else if (off_ff == OW'(7)) begin
                  do_disp = 1'b1;
                  if (word == PPP_IPV4)      disp_type = ETH_IPV4;
                  else if (word == PPP_IPV6) disp_type = ETH_IPV6;
               end
            end
            PH_IPV4: begin
               // Header fields at fixed offsets.
               case (off_ff)
                  OW'(0):  cap_in.ihl = (b[3:0] < IHL_MIN) ? IHL_MIN : b[3:0];
                  OW'(9):  cap_in.ip_protocol = b;
                  OW'(12): cap_in.src_ipv4[31:24] = b;
                  OW'(13): cap_in.src_ipv4[23:16] = b;
                  OW'(14): cap_in.src_ipv4[15:8]  = b;
                  OW'(15): cap_in.src_ipv4[7:0]   = b;
                  OW'(16): cap_in.dst_ipv4[31:24] = b;
                  OW'(17): cap_in.dst_ipv4[23:16] = b;
                  OW'(18): cap_in.dst_ipv4[15:8]  = b;
                  OW'(19): cap_in.dst_ipv4[7:0]   = b;
                  default: ;
               endcase
               hdr_len = {cap_in.ihl, 2'b00};
               udp_off = off_ff - OW'(hdr_len);
               // Non-UDP traffic ends after the addresses; UDP goes on past the options.
               if (cap_in.ip_protocol != IP_PROTO_UDP) begin
                  if (off_ff >= OW'(19)) phase_in = PH_DONE;
               end else if (off_ff >= OW'(hdr_len)) begin
                  case (udp_off) inside
                     OW'(0), OW'(2), OW'(4): hold_in = b;
                     OW'(1): cap_in.udp_src_port = word;
                     OW'(3): cap_in.udp_dst_port = word;
                     OW'(5): begin
                        cap_in.udp_length             = word;
                        cap_in.status_flags[FLG_UDP]  = 1'b1;
                        phase_in                      = PH_DONE;
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase

         // A complete type word selects the next header.
         if (do_disp) begin
            cap_in.final_ethertype = disp_type;
            off_in                 = '0;
            unique case (disp_type)
               ETH_VLAN: begin
                  if (tag_ff < TW'(MAX_TAGS)) begin
                     tag_in                        = tag_ff + TW'(1);
                     cap_in.status_flags[FLG_VLAN] = 1'b1;
                     phase_in                      = PH_VLAN;
                  end else begin
                     cap_in.status_flags[FLG_TAG_LIMIT] = 1'b1;
                     cap_in.l3_kind                     = L3_OTHER;
                     phase_in                           = PH_DONE;
                  end
               end
               ETH_PPPOE_SESS: begin
                  cap_in.status_flags[FLG_PPPOE] = 1'b1;
                  phase_in                       = PH_PPPOE;
               end
               ETH_IPV4: begin
                  cap_in.l3_kind = L3_IPV4;
                  phase_in       = PH_IPV4;
               end
               ETH_IPV6: begin
                  cap_in.l3_kind = L3_IPV6;
                  phase_in       = PH_DONE;
               end
               ETH_ARP: begin
                  cap_in.l3_kind = L3_ARP;
                  phase_in       = PH_DONE;
               end
               ETH_PPPOE_DISC: begin
                  cap_in.l3_kind = L3_PPPOE_DISC;
                  phase_in       = PH_DONE;
               end
               default: begin
                  cap_in.l3_kind = L3_OTHER;
                  phase_in       = PH_DONE;
               end
            endcase
         end
      end

      // The last byte closes the frame: build the summary and clear the state.
      if (beat.last_byte) begin
         flags_out = cap_in.status_flags;
         if (phase_in != PH_DONE) flags_out[FLG_TRUNC] = 1'b1;
         result.l3_kind          = cap_in.l3_kind;
         result.final_ethertype  = cap_in.final_ethertype;
         result.vlan_tci         = cap_in.vlan_tci;
         result.status_flags     = flags_out;
         result.pppoe_session_id = cap_in.pppoe_session_id;
         result.pppoe_length     = cap_in.pppoe_length;
         result.src_ipv4         = cap_in.src_ipv4;
         result.dst_ipv4         = cap_in.dst_ipv4;
         result.ip_protocol      = cap_in.ip_protocol;
         if (flags_out[FLG_UDP]) begin
            result.udp_src_port = cap_in.udp_src_port;
            result.udp_dst_port = cap_in.udp_dst_port;
            result.udp_length   = cap_in.udp_length;
         end
         phase_in = PH_MAC;
         pos_in   = '0;
         off_in   = '0;
         tag_in   = '0;
         hold_in  = '0;
         cap_in   = '0;
      end
   end

   // Parse state registers, advanced once per byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAC;
         pos_ff   <= '0;
         off_ff   <= '0;
         tag_ff   <= '0;
         hold_ff  <= '0;
         cap_ff   <= '0;
      end else if (beat_valid) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         off_ff   <= off_in;
         tag_ff   <= tag_in;
         hold_ff  <= hold_in;
         cap_ff   <= cap_in;
      end
   end

`ifndef SYNTHESIS
   // The tag counter never passes its limit.
   a_tag_bound: assert property (@(posedge clock) disable iff (reset)
      tag_ff <= TW'(MAX_TAGS))
      else $error("tag counter above limit");

   // The byte position never passes the frame size limit.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(MAX_FRAME_BYTES))
      else $error("byte position above limit");

   // A closed frame leaves the parser waiting for MAC addresses.
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      beat_valid && beat.last_byte |=> phase_ff == PH_MAC && pos_ff == '0)
      else $error("frame state not cleared after last byte");
`endif

endmodule

### rtl/ethernet_header_parser.sv
// Ethernet header parser top level: byte input register, frame parser and
// summary output register. The summary is registered once the last byte
// leaves the input register. Throughput: one byte per cycle, but a stalled
// summary holds back the input only when a further last byte waits.
// Reset (synchronous) empties both registers and returns to the MAC phase.
// Depends on ehp_pkg, ehp_if and ehp_frame_parser.
module ethernet_header_parser #(
   parameter int MAX_TAGS        = ehp_pkg::DEF_MAX_TAGS,
   parameter int MAX_FRAME_BYTES = ehp_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic     clock,
   input  logic     reset,
   ehp_req_if.sink  req_chan,
   ehp_rsp_if.source rsp_chan
);
   import ehp_pkg::*;

   logic     s1_valid_ff, s1_valid_in;
   beat_type s1_beat_ff,  s1_beat_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff,  rsp_data_in;
   logic     s1_adv;
   logic     req_accept;
   rsp_type  result;

   // A byte leaves the input register unless it closes a frame while a
   // summary is still waiting to be taken.
   assign s1_adv         = s1_valid_ff &&
                           (!s1_beat_ff.last_byte || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_accept     = req_chan.valid && req_chan.ready;

   ehp_frame_parser #(
      .MAX_TAGS        (MAX_TAGS),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (s1_adv),
      .beat       (s1_beat_ff),
      .result     (result)
   );

   // Next values of the input and output registers.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_beat_in   = s1_beat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         s1_valid_in          = 1'b1;
         s1_beat_in.data_byte = req_chan.data_byte;
         s1_beat_in.last_byte = req_chan.last_byte;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (s1_adv && s1_beat_ff.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers are reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_beat_ff  <= s1_beat_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Summary channel outputs.
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.l3_kind          = rsp_data_ff.l3_kind;
   assign rsp_chan.final_ethertype  = rsp_data_ff.final_ethertype;
   assign rsp_chan.vlan_tci         = rsp_data_ff.vlan_tci;
   assign rsp_chan.status_flags     = rsp_data_ff.status_flags;
   assign rsp_chan.pppoe_session_id = rsp_data_ff.pppoe_session_id;
   assign rsp_chan.pppoe_length     = rsp_data_ff.pppoe_length;
   assign rsp_chan.src_ipv4         = rsp_data_ff.src_ipv4;
   assign rsp_chan.dst_ipv4         = rsp_data_ff.dst_ipv4;
   assign rsp_chan.ip_protocol      = rsp_data_ff.ip_protocol;
   assign rsp_chan.udp_src_port     = rsp_data_ff.udp_src_port;
   assign rsp_chan.udp_dst_port     = rsp_data_ff.udp_dst_port;
   assign rsp_chan.udp_length       = rsp_data_ff.udp_length;

`ifndef SYNTHESIS
   // A last byte blocked by a waiting summary keeps the input closed.
   a_block_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_beat_ff.last_byte && rsp_valid_ff && !rsp_chan.ready
      |-> !req_chan.ready)
      else $error("input open while a frame end is blocked");

   // A held byte stays unchanged until it moves on.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_beat_ff))
      else $error("held byte lost or changed");

   // Every frame end that moves on produces a summary.
   a_summary_made: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_beat_ff.last_byte |=> rsp_valid_ff)
      else $error("frame end without summary");

   // The layer 3 kind is always a defined code.
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.l3_kind <= L3_PPPOE_DISC)
      else $error("undefined layer 3 kind");
`endif

endmodule
